// File: hw/rtl/lidar_point_polar_to_cartesian_core_assert.svh
// Assertion macros shared by the polar-to-Cartesian RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LIDAR_POINT_POLAR_TO_CARTESIAN_CORE_ASSERT_SVH
`define LIDAR_POINT_POLAR_TO_CARTESIAN_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent checked in the same cycle as the antecedent.
`define LP2C_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lp2c: assertion failed");
// Consequent checked in the cycle after the antecedent.
`define LP2C_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lp2c: assertion failed");
`else
`define LP2C_ASSERT_NOW(label, ante, cons)
`define LP2C_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/lp2c_pkg.sv
// Shared types, constants and helper functions for the polar-to-Cartesian core.
// No dependencies.
package lp2c_pkg;

    // Tunables
    localparam int ROTATION_STEPS = 20;
    localparam int FRACTION_BITS  = 4;

    // Fixed formats
    localparam int WORK_FRAC  = 30;
    localparam int TABLE_LEN  = 28;
    localparam int CELL_COUNT = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
    localparam int STEP_W     = $clog2(TABLE_LEN);
    localparam int WORD_W     = 32;
    localparam int DEPTH_W    = 24;
    localparam int MDEG_W     = 20;
    localparam int ANG_W      = 19;
    localparam int BAM_W      = 32;
    localparam int WORK_W     = DEPTH_W + WORK_FRAC + 4;
    localparam int Z_W        = BAM_W + 2;
    localparam int COORD_W    = 29;
    localparam int OUT_SHIFT  = WORK_FRAC - FRACTION_BITS;
    localparam int RND_W      = WORK_W + 1 - OUT_SHIFT;

    // Angle constants, millidegrees
    localparam int FULL_TURN_MDEG = 360000;
    localparam logic [MDEG_W-1:0] TWO_TURNS_20  = MDEG_W'(2 * FULL_TURN_MDEG);
    localparam logic [MDEG_W-1:0] FULL_TURN_20  = MDEG_W'(FULL_TURN_MDEG);
    localparam logic [ANG_W-1:0]  QUARTER_TURN  = ANG_W'(FULL_TURN_MDEG / 4);
    localparam logic [ANG_W-1:0]  ELEV_WRAP     = ANG_W'(FULL_TURN_MDEG + FULL_TURN_MDEG / 4);

    // mdeg -> binary angle: 360000 = 64 * 5625, so
    // bam = a*floor(2^26/5625) + floor((a*(2^26 mod 5625) + 2812) / 5625)
    localparam int BAM_PRE_SHIFT   = 6;
    localparam int BAM_DIV         = FULL_TURN_MDEG / (1 << BAM_PRE_SHIFT);
    localparam int BAM_HI_MUL      = (1 << (BAM_W - BAM_PRE_SHIFT)) / BAM_DIV;
    localparam int BAM_LO_MUL      = (1 << (BAM_W - BAM_PRE_SHIFT)) % BAM_DIV;
    localparam int BAM_BIAS        = (FULL_TURN_MDEG / 2) / (1 << BAM_PRE_SHIFT);
    localparam int BAM_RECIP_SHIFT = 30;
    localparam int BAM_RECIP       = (1 << BAM_RECIP_SHIFT) / BAM_DIV;

    // CORDIC gain compensation, Q32
    localparam logic [BAM_W-1:0] GAIN_Q32  = 32'd2608131496;
    localparam logic [64:0]      GAIN_HALF = 65'h0_8000_0000;

    // Register stages in the angle converter and in the gain scaler
    localparam int SCALE_LATENCY = 4;

    // Valid stages ahead of the output register
    localparam int PIPE_DEPTH = 2 + SCALE_LATENCY + 1 + CELL_COUNT
                              + SCALE_LATENCY + 1 + CELL_COUNT;

    localparam logic [WORK_W:0] RND_HALF = (WORK_W + 1)'(1) << (OUT_SHIFT - 1);
    localparam logic signed [RND_W-1:0] OUT_MAX_R =
        RND_W'((longint'(1) << (COORD_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] OUT_MIN_R =
        RND_W'(-(longint'(1) << (COORD_W - 1)));

    localparam logic [BAM_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    typedef struct packed {
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } point_t;

    typedef struct packed {
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } coord_t;

    // Data riding alongside a rotation
    typedef struct packed {
        logic [BAM_W-1:0]  angle;
        logic [WORK_W-1:0] side;
    } aux_t;

    // One CORDIC lane: x, y in Q30 two's complement, z residual angle
    typedef struct packed {
        logic [WORK_W-1:0] x;
        logic [WORK_W-1:0] y;
        logic [Z_W-1:0]    z;
        aux_t              aux;
    } lane_t;

    function automatic logic [BAM_W-1:0] atan_bam(input logic [STEP_W-1:0] idx);
        logic [BAM_W-1:0] val;
        val = '0;
        if (int'(idx) < TABLE_LEN)
        begin
            val = ATAN_TABLE[idx];
        end
        return val;
    endfunction

    // Reduce a 20-bit millidegree field modulo one turn
    function automatic logic [ANG_W-1:0] reduce_turn(input logic [MDEG_W-1:0] a);
        logic [MDEG_W-1:0] r;
        if (a >= TWO_TURNS_20)
        begin
            r = a - TWO_TURNS_20;
        end
        else if (a >= FULL_TURN_20)
        begin
            r = a - FULL_TURN_20;
        end
        else
        begin
            r = a;
        end
        return r[ANG_W-1:0];
    endfunction

    // Fold quadrants 1 and 2 into the CORDIC range: negate x, add a half turn
    function automatic lane_t fold_entry(input logic [WORK_W-1:0] mag,
                                         input logic [BAM_W-1:0] bam);
        lane_t lane;
        logic  flip;
        flip     = bam[BAM_W-1] ^ bam[BAM_W-2];
        lane.x   = flip ? (WORK_W'(0) - mag) : mag;
        lane.y   = '0;
        lane.z   = Z_W'($signed({bam[BAM_W-1] ^ flip, bam[BAM_W-2:0]}));
        lane.aux = '0;
        return lane;
    endfunction

    // Q30 -> FRACTION_BITS, round half up, saturate to COORD_W
    function automatic logic [COORD_W-1:0] round_coord(input logic [WORK_W-1:0] v);
        logic signed [WORK_W:0]  biased;
        logic signed [RND_W-1:0] shifted;
        logic [COORD_W-1:0]      res;
        biased  = $signed({v[WORK_W-1], v} + RND_HALF);
        shifted = RND_W'(biased >>> OUT_SHIFT);
        if (shifted > OUT_MAX_R)
        begin
            res = OUT_MAX_R[COORD_W-1:0];
        end
        else if (shifted < OUT_MIN_R)
        begin
            res = OUT_MIN_R[COORD_W-1:0];
        end
        else
        begin
            res = shifted[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/lp2c_bam_conv.sv
// Millidegree angle (already reduced to one turn) to 32-bit binary angle.
// Four register stages; uses lp2c_pkg.
module lp2c_bam_conv (
    input  logic                           clk,
    input  logic                           en,
    input  logic [lp2c_pkg::ANG_W-1:0]     angle,
    output logic [lp2c_pkg::BAM_W-1:0]     bam
);
    import lp2c_pkg::*;

    localparam int V_W   = 30;
    localparam int Q_W   = 18;
    localparam int HM_W  = ANG_W + 14;
    localparam int LM_W  = ANG_W + 12;
    localparam int P_W   = V_W + Q_W;

    logic [HM_W-1:0]  base_full;
    logic [LM_W-1:0]  v_full;
    logic [P_W-1:0]   recip_prod;
    logic [V_W-1:0]   back_prod;
    logic [V_W-1:0]   rem;

    logic [BAM_W-1:0] base_s1_next, base_s1_reg, base_s2_reg, base_s3_reg;
    logic [V_W-1:0]   v_s1_next, v_s1_reg, v_s2_reg;
    logic [Q_W-1:0]   qe_s2_next, qe_s2_reg;
    logic [Q_W-1:0]   q_s3_next, q_s3_reg;
    logic [BAM_W-1:0] bam_next, bam_reg;

    always_comb
    begin
        // split a*2^26 into whole multiples of the divisor and a remainder part
        base_full    = HM_W'(angle) * HM_W'(BAM_HI_MUL);
        base_s1_next = base_full[BAM_W-1:0];
        v_full       = LM_W'(angle) * LM_W'(BAM_LO_MUL) + LM_W'(BAM_BIAS);
        v_s1_next    = v_full[V_W-1:0];

        // quotient estimate by reciprocal, low by at most one
        recip_prod   = P_W'(v_s1_reg) * P_W'(BAM_RECIP);
        qe_s2_next   = recip_prod[BAM_RECIP_SHIFT +: Q_W];

        back_prod    = V_W'(qe_s2_reg) * V_W'(BAM_DIV);
        rem          = v_s2_reg - back_prod;
        q_s3_next    = qe_s2_reg + Q_W'(rem >= V_W'(BAM_DIV));

        bam_next     = base_s3_reg + BAM_W'(q_s3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_s1_reg <= base_s1_next;
            v_s1_reg    <= v_s1_next;
            base_s2_reg <= base_s1_reg;
            v_s2_reg    <= v_s1_reg;
            qe_s2_reg   <= qe_s2_next;
            base_s3_reg <= base_s2_reg;
            q_s3_reg    <= q_s3_next;
            bam_reg     <= bam_next;
        end
    end

    assign bam = bam_reg;

endmodule

// File: hw/rtl/lp2c_gain_scale.sv
// Scales a Q30 value by the CORDIC gain (Q32), magnitude-wise with rounding.
// Four register stages, side data travels along; uses lp2c_pkg.
module lp2c_gain_scale (
    input  logic                            clk,
    input  logic                            en,
    input  logic [lp2c_pkg::WORK_W-1:0]     mag,
    input  lp2c_pkg::aux_t                  aux,
    output logic [lp2c_pkg::WORK_W-1:0]     scaled,
    output lp2c_pkg::aux_t                  scaled_aux
);
    import lp2c_pkg::*;

    localparam int HI_W = WORK_W - BAM_W;
    localparam int LO_W = 2 * BAM_W;

    logic [64:0]       lo_rnd;

    logic              neg_g1_reg, neg_g2_reg, neg_g3_reg;
    logic [WORK_W-1:0] abs_g1_next, abs_g1_reg;
    logic [WORK_W-1:0] hi_g2_next, hi_g2_reg;
    logic [LO_W-1:0]   lo_g2_next, lo_g2_reg;
    logic [WORK_W-1:0] p_g3_next, p_g3_reg;
    logic [WORK_W-1:0] out_next, out_reg;
    aux_t              aux_g1_reg, aux_g2_reg, aux_g3_reg, aux_g4_reg;

    always_comb
    begin
        abs_g1_next = mag[WORK_W-1] ? (WORK_W'(0) - mag) : mag;

        hi_g2_next  = WORK_W'(abs_g1_reg[BAM_W +: HI_W]) * WORK_W'(GAIN_Q32);
        lo_g2_next  = LO_W'(abs_g1_reg[BAM_W-1:0]) * LO_W'(GAIN_Q32);

        // low half rounds half up before the high half is added
        lo_rnd      = 65'(lo_g2_reg) + GAIN_HALF;
        p_g3_next   = hi_g2_reg + WORK_W'(lo_rnd[64:BAM_W]);

        out_next    = neg_g3_reg ? (WORK_W'(0) - p_g3_reg) : p_g3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_g1_reg <= mag[WORK_W-1];
            abs_g1_reg <= abs_g1_next;
            aux_g1_reg <= aux;
            neg_g2_reg <= neg_g1_reg;
            hi_g2_reg  <= hi_g2_next;
            lo_g2_reg  <= lo_g2_next;
            aux_g2_reg <= aux_g1_reg;
            neg_g3_reg <= neg_g2_reg;
            p_g3_reg   <= p_g3_next;
            aux_g3_reg <= aux_g2_reg;
            out_reg    <= out_next;
            aux_g4_reg <= aux_g3_reg;
        end
    end

    assign scaled     = out_reg;
    assign scaled_aux = aux_g4_reg;

endmodule

// File: hw/rtl/lp2c_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation, registered.
// Step index is tied per instance; uses lp2c_pkg.
module lp2c_cordic_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [lp2c_pkg::STEP_W-1:0]   step,
    input  lp2c_pkg::lane_t               lane_in,
    output lp2c_pkg::lane_t               lane_out
);
    import lp2c_pkg::*;

    logic signed [WORK_W-1:0] dx, dy;
    logic signed [Z_W-1:0]    dz;
    lane_t                    lane_next, lane_reg;

    always_comb
    begin
        dx = $signed(lane_in.y) >>> step;
        dy = $signed(lane_in.x) >>> step;
        dz = $signed({2'b00, atan_bam(step)});
        lane_next.aux = lane_in.aux;
        if (!lane_in.z[Z_W-1])
        begin
            lane_next.x = WORK_W'($signed(lane_in.x) - dx);
            lane_next.y = WORK_W'($signed(lane_in.y) + dy);
            lane_next.z = Z_W'($signed(lane_in.z) - dz);
        end
        else
        begin
            lane_next.x = WORK_W'($signed(lane_in.x) + dx);
            lane_next.y = WORK_W'($signed(lane_in.y) - dy);
            lane_next.z = Z_W'($signed(lane_in.z) + dz);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// File: hw/rtl/lidar_point_polar_to_cartesian_core.sv
// Lidar point converter top level: polar (depth, theta, phi) to Cartesian x, y, z.
// Uses lp2c_pkg, lp2c_bam_conv, lp2c_gain_scale, lp2c_cordic_cell.
//
// Usage
//   point channel: one beat carries one lidar point as two 32-bit words
//   (depth mm + theta high bits, theta low bits + phi mdeg).
//   coord channel: one beat carries x, y, z as 29-bit signed values in
//   1/16 mm (FRACTION_BITS fraction bits), rounded and saturated.
//   Both channels: beat moves when valid is high and stall is low.
// Throughput: one point per clock while coord_stall stays low.
// Path: stage 0 and stage 1, the angle converters beside the first gain
//   scaler, the entry register and CORDIC cell chain of rotation one, the
//   second gain scaler, the entry register and cell chain of rotation two,
//   then the result register; one micro-rotation per cell.
// Stall: the pipeline advances as one unit. While a result waits in the
//   output register it still moves if its last stage is empty, so a
//   bubble is squeezed out; point_stall rises only when the last stage
//   and the output register both hold a point and coord_stall is high.
// Reset: clears stage valid bits and the output valid; data regs unreset.
`include "lidar_point_polar_to_cartesian_core_assert.svh"
module lidar_point_polar_to_cartesian_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_stall,
    input  lp2c_pkg::point_t   point,
    output logic               coord_valid,
    input  logic               coord_stall,
    output lp2c_pkg::coord_t   coord
);
    import lp2c_pkg::*;

    localparam int LAST = PIPE_DEPTH - 1;

    // ---------------- pipeline control ----------------
    logic                  pipe_en;
    logic                  out_load;
    logic [PIPE_DEPTH-1:0] pipe_valid_next, pipe_valid_reg;
    logic                  coord_valid_next, coord_valid_reg;

    // ---------------- datapath ----------------
    logic [MDEG_W-1:0]  theta_raw, phi_raw;
    logic [DEPTH_W-1:0] depth_s0_reg, depth_s1_reg;
    logic [ANG_W-1:0]   theta_s0_next, theta_s0_reg;
    logic [ANG_W-1:0]   phi_s0_next, phi_s0_reg, phi_s1_reg;
    logic [ANG_W-1:0]   elev_s1_next, elev_s1_reg;

    logic [WORK_W-1:0]  mag1;
    logic [BAM_W-1:0]   elev_bam, phi_bam;
    logic [WORK_W-1:0]  scaled1, scaled2;
    aux_t               aux2_in, aux2_out;

    lane_t              lane1_next, lane1_reg;
    lane_t              lane2_next, lane2_reg;
    lane_t              chain1 [CELL_COUNT+1];
    lane_t              chain2 [CELL_COUNT+1];

    coord_t             coord_next, coord_reg;

    // Whole pipe moves unless the last stage is full and cannot drain
    assign pipe_en     = !coord_valid_reg || !coord_stall || !pipe_valid_reg[LAST];
    assign out_load    = pipe_en && pipe_valid_reg[LAST];
    assign point_stall = !pipe_en;

    always_comb
    begin
        pipe_valid_next = pipe_valid_reg;
        if (pipe_en)
        begin
            pipe_valid_next = {pipe_valid_reg[PIPE_DEPTH-2:0], point_valid};
        end
        if (out_load)
        begin
            coord_valid_next = 1'b1;
        end
        else
        begin
            coord_valid_next = coord_valid_reg && coord_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg  <= '0;
            coord_valid_reg <= 1'b0;
        end
        else
        begin
            pipe_valid_reg  <= pipe_valid_next;
            coord_valid_reg <= coord_valid_next;
        end
    end

    // Stage 0: unpack fields, reduce both angles to one turn
    always_comb
    begin
        theta_raw     = {point.first_word[WORD_W-1:DEPTH_W], point.second_word[11:0]};
        phi_raw       = point.second_word[WORD_W-1:WORD_W-MDEG_W];
        theta_s0_next = reduce_turn(theta_raw);
        phi_s0_next   = reduce_turn(phi_raw);
    end

    // Stage 1: elevation = (90000 - theta) mod 360000
    always_comb
    begin
        if (theta_s0_reg <= QUARTER_TURN)
        begin
            elev_s1_next = QUARTER_TURN - theta_s0_reg;
        end
        else
        begin
            elev_s1_next = ELEV_WRAP - theta_s0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            depth_s0_reg <= point.first_word[DEPTH_W-1:0];
            theta_s0_reg <= theta_s0_next;
            phi_s0_reg   <= phi_s0_next;
            depth_s1_reg <= depth_s0_reg;
            elev_s1_reg  <= elev_s1_next;
            phi_s1_reg   <= phi_s0_reg;
        end
    end

    // Depth as Q30 magnitude
    assign mag1 = WORK_W'({depth_s1_reg, {WORK_FRAC{1'b0}}});

    lp2c_bam_conv u_elev_bam (
        .clk   (clk),
        .en    (pipe_en),
        .angle (elev_s1_reg),
        .bam   (elev_bam)
    );

    lp2c_bam_conv u_phi_bam (
        .clk   (clk),
        .en    (pipe_en),
        .angle (phi_s1_reg),
        .bam   (phi_bam)
    );

    lp2c_gain_scale u_gain1 (
        .clk        (clk),
        .en         (pipe_en),
        .mag        (mag1),
        .aux        ('0),
        .scaled     (scaled1),
        .scaled_aux ()
    );

    // Entry of rotation one: rotate (depth, 0) by elevation, phi rides along
    always_comb
    begin
        lane1_next           = fold_entry(scaled1, elev_bam);
        lane1_next.aux.angle = phi_bam;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            lane1_reg <= lane1_next;
        end
    end

    assign chain1[0] = lane1_reg;

    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_rot1
        lp2c_cordic_cell u_cell (
            .clk      (clk),
            .en       (pipe_en),
            .step     (STEP_W'(i)),
            .lane_in  (chain1[i]),
            .lane_out (chain1[i+1])
        );
    end

    // r = x of rotation one; z = y of rotation one travels as side data
    always_comb
    begin
        aux2_in.angle = chain1[CELL_COUNT].aux.angle;
        aux2_in.side  = chain1[CELL_COUNT].y;
    end

    lp2c_gain_scale u_gain2 (
        .clk        (clk),
        .en         (pipe_en),
        .mag        (chain1[CELL_COUNT].x),
        .aux        (aux2_in),
        .scaled     (scaled2),
        .scaled_aux (aux2_out)
    );

    // Entry of rotation two: rotate (r, 0) by phi
    always_comb
    begin
        lane2_next          = fold_entry(scaled2, aux2_out.angle);
        lane2_next.aux.side = aux2_out.side;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            lane2_reg <= lane2_next;
        end
    end

    assign chain2[0] = lane2_reg;

    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_rot2
        lp2c_cordic_cell u_cell (
            .clk      (clk),
            .en       (pipe_en),
            .step     (STEP_W'(i)),
            .lane_in  (chain2[i]),
            .lane_out (chain2[i+1])
        );
    end

    // Output register: round Q30 to the output format and saturate
    always_comb
    begin
        coord_next.coord_x = round_coord(chain2[CELL_COUNT].x);
        coord_next.coord_y = round_coord(chain2[CELL_COUNT].y);
        coord_next.coord_z = round_coord(chain2[CELL_COUNT].aux.side);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord_valid = coord_valid_reg;
    assign coord       = coord_reg;

    // ---------------- checks ----------------
    `LP2C_ASSERT_NEXT(a_accept_enters, point_valid && !point_stall, pipe_valid_reg[0])
    `LP2C_ASSERT_NEXT(a_last_reaches_out, pipe_en && pipe_valid_reg[LAST], coord_valid)
    `LP2C_ASSERT_NEXT(a_frozen_pipe_holds, !pipe_en, $stable(pipe_valid_reg))
    `LP2C_ASSERT_NEXT(a_drain_empties, coord_valid && !coord_stall && !pipe_valid_reg[LAST], !coord_valid)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for lidar_point_polar_to_cartesian_core: directed and random points
// go in, x/y/z beats are checked against a bit-exact CORDIC predictor kept here.
// Depends on lp2c_pkg (point_t, coord_t) and the core RTL only.
module testbench;

    import lp2c_pkg::*;

    // Predictor settings, mirroring the core's defaults
    localparam int  TURN_STEPS = 20;            // CORDIC micro-rotations per rotation
    localparam int  OUT_FRAC   = 4;             // fraction bits of x/y/z
    localparam int  Q_FRAC     = 30;            // working fraction bits
    localparam int  ATAN_LEN   = 28;
    localparam longint unsigned K_GAIN = 64'd2608131496;   // 1/K in Q32
    localparam longint COORD_HI = 268435455;
    localparam longint COORD_LO = -268435456;

    // Final drain wait length, and run limits
    localparam int PIPE_LAT     = 2 * TURN_STEPS + 12;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 300000;

    localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    // One directed row: point fields, plus a typed-in result where it is obvious
    typedef struct {
        logic [23:0] depth;
        logic [19:0] theta;
        logic [19:0] phi;
        bit          typed;
        coord_t      want;
    } row_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   point_valid;
    logic   point_stall;
    point_t point;
    logic   coord_valid;
    logic   coord_stall;
    coord_t coord;

    coord_t coord_due [$];      // x/y/z still owed by the core, oldest first
    bit     want_typed;         // current beat carries a typed-in result
    coord_t want_coord;
    bit     quiet = 1'b0;       // no idling on either side while set
    int     faults = 0;
    int     results_seen = 0;
    int     directed_sent = 0;
    int     random_sent = 0;
    int     cycle_count = 0;

    row_t   dir_rows [19];

    lidar_point_polar_to_cartesian_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .coord_valid (coord_valid),
        .coord_stall (coord_stall),
        .coord       (coord)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the pipe hangs or loses beats
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed",
                     cycle_count, coord_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Multiply by the CORDIC gain on the magnitude; low half rounds half up
    function automatic longint gain_comp(input longint v);
        longint unsigned m;
        longint unsigned p;
        m = (v < 0) ? -v : v;
        p = (m >> 32) * K_GAIN + (((m & 64'hFFFF_FFFF) * K_GAIN + 64'h8000_0000) >> 32);
        return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    // Millidegrees to a 32-bit binary angle, full turn = 2^32, rounded
    function automatic logic [31:0] mdeg_to_turn(input logic [19:0] a);
        longint unsigned t;
        t = ((64'(a) % 64'd360000) << 32) + 64'd180000;
        return 32'(t / 64'd360000);
    endfunction

    // Rotate (mag, 0) by ang: cx = mag*cos, sy = mag*sin, both Q30
    function automatic void cordic_turn(input longint mag, input logic [31:0] ang,
                                        output longint cx, output longint sy);
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        logic [31:0] a;
        x = gain_comp(mag);
        y = 0;
        a = ang;
        // second and third quadrants: flip the vector, add half a turn
        if (a[31] ^ a[30])
        begin
            x = -x;
            a = a + 32'h8000_0000;
        end
        z = $signed(a);
        for (int i = 0; i < TURN_STEPS && i < ATAN_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TURN[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TURN[i]);
            end
        end
        cx = x;
        sy = y;
    endfunction

    // Q30 to OUT_FRAC bits, half up, clamp to 29 bits
    function automatic logic [28:0] round_q30(input longint v);
        longint r;
        r = (v + (longint'(1) << (Q_FRAC - OUT_FRAC - 1))) >>> (Q_FRAC - OUT_FRAC);
        if (r > COORD_HI)
        begin
            r = COORD_HI;
        end
        else if (r < COORD_LO)
        begin
            r = COORD_LO;
        end
        return r[28:0];
    endfunction

    function automatic coord_t polar_to_coord(input point_t p);
        logic [23:0] depth;
        logic [19:0] theta;
        logic [19:0] phi;
        logic [19:0] elev;
        longint      r;
        longint      z;
        longint      x;
        longint      y;
        coord_t      c;
        depth = p.first_word[23:0];
        theta = {p.first_word[31:24], p.second_word[11:0]};
        phi   = p.second_word[31:12];
        elev  = 20'((64'd450000 - 64'(theta) % 64'd360000) % 64'd360000);
        cordic_turn(longint'(depth) << Q_FRAC, mdeg_to_turn(elev), r, z);
        cordic_turn(r, mdeg_to_turn(phi), x, y);
        c.coord_x = round_q30(x);
        c.coord_y = round_q30(y);
        c.coord_z = round_q30(z);
        return c;
    endfunction

    function automatic point_t make_point(input logic [23:0] depth, input logic [19:0] theta,
                                          input logic [19:0] phi);
        point_t p;
        p.first_word  = {theta[19:12], depth};
        p.second_word = {phi, theta[11:0]};
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------

    function automatic void check_lane(input string tag, input logic [28:0] want,
                                       input logic [28:0] got);
        if (want !== got)
        begin
            if (faults < 10)
            begin
                $display("%s mismatch on result %0d: want %0d got %0d",
                         tag, results_seen, $signed(want), $signed(got));
            end
            faults++;
        end
    endfunction

    // Point beats queue a prediction; coord beats retire the oldest one.
    // Sampled at the rising edge, inputs having settled since the falling edge.
    always @(posedge clk)
    begin
        coord_t due;
        if (rst_n)
        begin
            if (point_valid && !point_stall)
            begin
                coord_due.insert(coord_due.size(),
                                 want_typed ? want_coord : polar_to_coord(point));
            end
            if (coord_valid && !coord_stall)
            begin
                if (coord_due.size() == 0)
                begin
                    if (faults < 10)
                    begin
                        $display("coord beat with nothing owed: x %0d y %0d z %0d",
                                 $signed(coord.coord_x), $signed(coord.coord_y),
                                 $signed(coord.coord_z));
                    end
                    faults++;
                end
                else
                begin
                    due = coord_due.pop_front();
                    check_lane("x", due.coord_x, coord.coord_x);
                    check_lane("y", due.coord_y, coord.coord_y);
                    check_lane("z", due.coord_z, coord.coord_z);
                end
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall ahead of each coord beat
    // ------------------------------------------------------------------
    initial
    begin
        int hold;
        coord_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 11);
            if (hold > 0)
            begin
                @(negedge clk);
                coord_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                coord_stall <= 1'b0;
            end
            do @(posedge clk); while (!(coord_valid && !coord_stall));
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Optional gap with valid low, then present the beat and hold it until taken.
    // At most one update of point_valid per falling edge.
    task automatic feed_point(input point_t p, input bit typed, input coord_t want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        point_valid <= 1'b1;
        point       <= p;
        want_typed   = typed;
        want_coord   = want;
        do @(posedge clk); while (point_stall);
    endtask

    initial
    begin
        point_t      p;
        logic [23:0] depth;
        logic [19:0] theta;
        logic [19:0] phi;

        rst_n       = 1'b0;
        point_valid = 1'b0;
        point       = '0;
        want_typed  = 1'b0;
        want_coord  = '0;

        // Zero depth gives exact zeros, so those rows carry their result.
        // The rest hit the axes, quadrant folds, wrap of the angle fields
        // past one and two turns, and the field extremes.
        dir_rows = '{
            '{24'd0,       20'd0,       20'd0,       1'b1, '0},
            '{24'd0,       20'hFFFFF,   20'hFFFFF,   1'b1, '0},
            '{24'd0,       20'd123456,  20'd654321,  1'b1, '0},
            '{24'hFFFFFF,  20'd90000,   20'd0,       1'b0, '0},   // flat, along x
            '{24'hFFFFFF,  20'd0,       20'd0,       1'b0, '0},   // straight up
            '{24'hFFFFFF,  20'd180000,  20'd0,       1'b0, '0},   // straight down
            '{24'hFFFFFF,  20'hFFFFF,   20'hFFFFF,   1'b0, '0},
            '{24'd1,       20'd90000,   20'd90000,   1'b0, '0},
            '{24'd1,       20'd0,       20'd1,       1'b0, '0},
            '{24'd1000,    20'd45000,   20'd180000,  1'b0, '0},
            '{24'd1000,    20'd135000,  20'd270000,  1'b0, '0},
            '{24'd4096,    20'd359999,  20'd359999,  1'b0, '0},
            '{24'd4096,    20'd360000,  20'd360000,  1'b0, '0},   // one turn wraps to 0
            '{24'd4096,    20'd720000,  20'd720000,  1'b0, '0},   // two turns
            '{24'd4096,    20'd719999,  20'd1048575, 1'b0, '0},
            '{24'h800000,  20'd270000,  20'd89999,   1'b0, '0},
            '{24'h800000,  20'd225000,  20'd135000,  1'b0, '0},
            '{24'h5A5A5A,  20'hAAAAA,   20'h55555,   1'b0, '0},
            '{24'hA5A5A5,  20'h55555,   20'hAAAAA,   1'b0, '0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[k])
        begin
            feed_point(make_point(dir_rows[k].depth, dir_rows[k].theta, dir_rows[k].phi),
                       dir_rows[k].typed, dir_rows[k].want);
            directed_sent++;
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // every fourth block of 100 beats runs with no idling at all
            if (n % 100 == 0)
            begin
                quiet = ((n / 100) % 4 == 1);
            end

            // let the pipe run dry once, mid-run, with valid low
            if (n == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                point_valid <= 1'b0;
                while (coord_due.size() != 0) @(posedge clk);
            end

            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // raw words: angle fields often past a full turn
                    p = {$urandom, $urandom};
                end
                2:
                begin
                    // within two mdeg of an axis, shifted up by one turn (two at the top choice)
                    depth = 24'($urandom);
                    theta = 20'(90000 * $urandom_range(0, 4) + 359998 + $urandom_range(0, 4));
                    phi   = 20'(90000 * $urandom_range(0, 4) + 359998 + $urandom_range(0, 4));
                    p     = make_point(depth, theta, phi);
                end
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       depth = 24'($urandom_range(0, 255));
                        1:       depth = 24'($urandom_range(0, 65535));
                        default: depth = 24'($urandom);
                    endcase
                    theta = 20'($urandom_range(0, 359999));
                    phi   = 20'($urandom_range(0, 359999));
                    p     = make_point(depth, theta, phi);
                end
            endcase
            feed_point(p, 1'b0, '0);
            random_sent++;
        end

        @(negedge clk);
        point_valid <= 1'b0;
        quiet = 1'b0;
        while (coord_due.size() != 0) @(posedge clk);
        repeat (2 * PIPE_LAT) @(posedge clk);

        $display("sent %0d directed and %0d random points under random idling",
                 directed_sent, random_sent);
        $display("checked %0d x/y/z beats, %0d field or beat faults", results_seen, faults);
        if (faults == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
